// File: hdl/sbq_pkg.sv
// ----------------------------------------------------------------------------
// sbq_pkg
// shared types and constants of the stereo biquad unit
// ----------------------------------------------------------------------------
package sbq_pkg;

    localparam int COEF_BITS = 32;

    typedef enum logic [2:0] {
        REG_B0,
        REG_B1,
        REG_B2,
        REG_A1,
        REG_A2
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PH1,
        ST_MID,
        ST_PH2,
        ST_FIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] b0;
        logic signed [COEF_BITS-1:0] b1;
        logic signed [COEF_BITS-1:0] b2;
        logic signed [COEF_BITS-1:0] a1;
        logic signed [COEF_BITS-1:0] a2;
    } t_coefs;

    typedef struct packed {
        logic clr;
        logic en;
        logic last;
    } t_mul_ctl;

    typedef struct packed {
        logic load;
        logic step;
        logic last;
        logic phase2;
        logic mid;
        logic fin;
    } t_chan_ctl;

endpackage

// File: hdl/sbq_ser_mul.sv
// ----------------------------------------------------------------------------
// sbq_ser_mul
// serial-parallel signed multiplier, data one bit per cycle lsb first while i_ctl.en is high
// ----------------------------------------------------------------------------
module sbq_ser_mul
    import sbq_pkg::*;
#(
    parameter int N = 32
) (
    input  logic                          i_clk,
    input  t_mul_ctl                      i_ctl,
    input  logic                          i_bit,
    input  logic signed [COEF_BITS-1:0]   i_coef,
    output logic signed [COEF_BITS+N:0]   o_prod
);

    logic signed [COEF_BITS:0]   r_h;
    logic        [N-1:0]         r_l;
    logic signed [COEF_BITS+1:0] w_c;
    logic signed [COEF_BITS+1:0] w_add;
    logic signed [COEF_BITS+1:0] w_sum;

    assign w_c = (COEF_BITS+2)'(i_coef);

    always_comb begin
        if (!i_bit) begin
            w_add = '0;
        end else if (i_ctl.last) begin
            w_add = -w_c;
        end else begin
            w_add = w_c;
        end
        w_sum = (COEF_BITS+2)'(r_h) + w_add;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_h <= '0;
            r_l <= '0;
        end else if (i_ctl.en) begin
            r_h <= w_sum[COEF_BITS+1:1];
            r_l <= {w_sum[0], r_l[N-1:1]};
        end
    end

    assign o_prod = {r_h, r_l};

endmodule

// File: hdl/sbq_chan.sv
// ----------------------------------------------------------------------------
// sbq_chan
// one channel of the biquad: serial products, delay state and saturation
// ----------------------------------------------------------------------------
module sbq_chan
    import sbq_pkg::*;
#(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 28,
    parameter int GUARD_BITS     = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_chan_ctl                     i_ctl,
    input  t_coefs                        i_coefs,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    output logic                          o_clip
);

    localparam int N  = SAMPLE_BITS + GUARD_BITS;
    localparam int YW = SAMPLE_BITS + GUARD_BITS;
    localparam int DW = SAMPLE_BITS + GUARD_BITS + 2;
    localparam int PW = COEF_BITS + 1 + N;
    localparam int QW = PW - COEF_FRAC_BITS;
    localparam int AW = ((QW > DW) ? QW : DW) + 2;

    logic        [N-1:0]  r_sh;
    logic signed [YW-1:0] r_y;
    logic signed [DW-1:0] r_d1;
    logic signed [DW-1:0] r_d2;
    logic signed [AW-1:0] r_t1;
    logic signed [AW-1:0] r_q2;
    logic                 r_clip;

    t_mul_ctl                    w_mctl;
    logic signed [COEF_BITS-1:0] w_c1;
    logic signed [COEF_BITS-1:0] w_c2;
    logic signed [PW-1:0]        w_p0;
    logic signed [PW-1:0]        w_p1;
    logic signed [PW-1:0]        w_p2;
    logic signed [QW-1:0]        w_q0;
    logic signed [QW-1:0]        w_q1;
    logic signed [QW-1:0]        w_q2;
    logic        [N-1:0]         w_x;
    logic signed [AW-1:0]        w_ysum;
    logic signed [AW-1:0]        w_n1;
    logic signed [AW-1:0]        w_n2;
    logic                        w_yfit;
    logic                        w_n1fit;
    logic                        w_n2fit;
    logic signed [YW-1:0]        w_ysat;
    logic signed [DW-1:0]        w_n1sat;
    logic signed [DW-1:0]        w_n2sat;

    assign w_mctl.clr  = i_ctl.load | i_ctl.mid;
    assign w_mctl.en   = i_ctl.step;
    assign w_mctl.last = i_ctl.last;

    assign w_c1 = i_ctl.phase2 ? i_coefs.a1 : i_coefs.b1;
    assign w_c2 = i_ctl.phase2 ? i_coefs.a2 : i_coefs.b2;

    sbq_ser_mul #(.N(N)) u_mul0 (
        .i_clk  (i_clk),
        .i_ctl  (w_mctl),
        .i_bit  (r_sh[0]),
        .i_coef (i_coefs.b0),
        .o_prod (w_p0)
    );

    sbq_ser_mul #(.N(N)) u_mul1 (
        .i_clk  (i_clk),
        .i_ctl  (w_mctl),
        .i_bit  (r_sh[0]),
        .i_coef (w_c1),
        .o_prod (w_p1)
    );

    sbq_ser_mul #(.N(N)) u_mul2 (
        .i_clk  (i_clk),
        .i_ctl  (w_mctl),
        .i_bit  (r_sh[0]),
        .i_coef (w_c2),
        .o_prod (w_p2)
    );

    // floor shift of each product
    assign w_q0 = $signed(w_p0[PW-1:COEF_FRAC_BITS]);
    assign w_q1 = $signed(w_p1[PW-1:COEF_FRAC_BITS]);
    assign w_q2 = $signed(w_p2[PW-1:COEF_FRAC_BITS]);

    assign w_x = N'(i_sample) << GUARD_BITS;

    assign w_ysum = AW'(w_q0) + AW'(r_d1);
    assign w_n1   = r_t1 - AW'(w_q1);
    assign w_n2   = r_q2 - AW'(w_q2);

    assign w_yfit  = (&w_ysum[AW-1:YW-1]) | ~(|w_ysum[AW-1:YW-1]);
    assign w_n1fit = (&w_n1[AW-1:DW-1]) | ~(|w_n1[AW-1:DW-1]);
    assign w_n2fit = (&w_n2[AW-1:DW-1]) | ~(|w_n2[AW-1:DW-1]);

    assign w_ysat  = w_yfit  ? w_ysum[YW-1:0] : {w_ysum[AW-1], {(YW-1){~w_ysum[AW-1]}}};
    assign w_n1sat = w_n1fit ? w_n1[DW-1:0]   : {w_n1[AW-1], {(DW-1){~w_n1[AW-1]}}};
    assign w_n2sat = w_n2fit ? w_n2[DW-1:0]   : {w_n2[AW-1], {(DW-1){~w_n2[AW-1]}}};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_sh <= w_x;
        end else if (i_ctl.mid) begin
            r_sh <= w_ysat;
        end else if (i_ctl.step) begin
            r_sh <= r_sh >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mid) begin
            r_y  <= w_ysat;
            r_t1 <= AW'(w_q1) + AW'(r_d2);
            r_q2 <= AW'(w_q2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1   <= '0;
            r_d2   <= '0;
            r_clip <= 1'b0;
        end else if (i_ctl.mid) begin
            r_clip <= ~w_yfit;
        end else if (i_ctl.fin) begin
            r_d1   <= w_n1sat;
            r_d2   <= w_n2sat;
            r_clip <= r_clip | ~w_n1fit | ~w_n2fit;
        end
    end

    assign o_sample = r_y[YW-1:GUARD_BITS];
    assign o_clip   = r_clip;

endmodule

// File: hdl/stereo_biquad_tdf2_unit.sv
// ----------------------------------------------------------------------------
// stereo_biquad_tdf2_unit
// stereo second-order iir section, transposed direct form ii, fixed point
// ----------------------------------------------------------------------------
// s_axis carries one stereo pair per beat (left low, right above it);
// m_axis returns the filtered pair with a clip flag on tuser.
// coefficients b0 b1 b2 a1 a2 (q3.28) sit on the apb port at 0x00..0x10;
// write them only while the unit is idle.
// each sample is fed to three bit-serial multipliers per channel, one bit
// a cycle: first pass x (SAMPLE_BITS+GUARD_BITS bits), second pass y.
// a pair runs through the states ph1 (x pass), mid (y update), ph2 (y pass),
// fin (delay update) and done (load of the output register); a new pair is
// taken only after the previous one has reached the output register.
// s_axis_tready is high only between pairs.
// a new pair is taken while the previous result still waits on m_axis;
// if the receiver stalls, the next result waits in the unit until the
// output register frees up.
// reset (synchronous, active low) clears the delays, restores b0 = 1.0 and
// the other coefficients to zero, and empties the output register.
// ----------------------------------------------------------------------------
module stereo_biquad_tdf2_unit
    import sbq_pkg::*;
#(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 28,
    parameter int GUARD_BITS     = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // left_in, right_in
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // left_out, right_out
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
    // clipped
    output logic                   m_axis_tuser,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [4:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int TDW   = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int N     = SAMPLE_BITS + GUARD_BITS;
    localparam int CNT_W = $clog2(N);
    localparam logic [CNT_W-1:0]     CNT_LAST = CNT_W'(N-1);
    localparam logic [COEF_BITS-1:0] B0_RESET = COEF_BITS'(1) << COEF_FRAC_BITS;

    t_state               r_state;
    t_state               n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;
    t_chan_ctl            w_ctl;
    logic                 w_out_load;
    t_coefs               r_coefs;
    logic                 w_wr;

    logic signed [SAMPLE_BITS-1:0] w_left;
    logic signed [SAMPLE_BITS-1:0] w_right;
    logic                          w_lclip;
    logic                          w_rclip;

    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_left;
    logic [SAMPLE_BITS-1:0] r_out_right;
    logic                   r_out_clip;

    // configuration port
    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= B0_RESET;
            r_coefs.b1 <= '0;
            r_coefs.b2 <= '0;
            r_coefs.a1 <= '0;
            r_coefs.a2 <= '0;
        end else if (w_wr) begin
            case (paddr[4:2])
                REG_B0:  r_coefs.b0 <= pwdata;
                REG_B1:  r_coefs.b1 <= pwdata;
                REG_B2:  r_coefs.b2 <= pwdata;
                REG_A1:  r_coefs.a1 <= pwdata;
                REG_A2:  r_coefs.a2 <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_B0:  prdata = r_coefs.b0;
            REG_B1:  prdata = r_coefs.b1;
            REG_B2:  prdata = r_coefs.b2;
            REG_A1:  prdata = r_coefs.a1;
            REG_A2:  prdata = r_coefs.a2;
            default: prdata = '0;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        w_ctl      = '0;
        w_out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    w_ctl.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_PH1;
                end
            end
            ST_PH1: begin
                w_ctl.step = 1'b1;
                w_ctl.last = (r_cnt == CNT_LAST);
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_MID;
                end
            end
            ST_MID: begin
                w_ctl.mid = 1'b1;
                n_state   = ST_PH2;
            end
            ST_PH2: begin
                w_ctl.step   = 1'b1;
                w_ctl.phase2 = 1'b1;
                w_ctl.last   = (r_cnt == CNT_LAST);
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                w_ctl.fin    = 1'b1;
                w_ctl.phase2 = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);

    sbq_chan #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .GUARD_BITS     (GUARD_BITS)
    ) u_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_coefs  (r_coefs),
        .i_sample ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
        .o_sample (w_left),
        .o_clip   (w_lclip)
    );

    sbq_chan #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .GUARD_BITS     (GUARD_BITS)
    ) u_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_coefs  (r_coefs),
        .i_sample ($signed(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
        .o_sample (w_right),
        .o_clip   (w_rclip)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_left  <= w_left;
            r_out_right <= w_right;
            r_out_clip  <= w_lclip | w_rclip;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDW'({r_out_right, r_out_left});
    assign m_axis_tuser  = r_out_clip;

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == ST_PH1))
        else $error("accepted beat did not start the first pass");

    a_ph2_from_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_PH2) |-> ($past(r_state) == ST_MID))
        else $error("second pass entered without the y update");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && n_state == ST_IDLE) |=> m_axis_tvalid)
        else $error("finished pair did not reach the output register");

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_cnt == '0))
        else $error("bit counter not cleared between pairs");
`endif

endmodule

// File: tb/stereo_biquad_tdf2_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_biquad_tdf2_unit_test
// drives stereo pairs into the biquad unit under several coefficient sets and
// handshake patterns, and compares every output beat with a fixed value from
// the plan or a bit-exact fixed-point model of the tdf2 section in this file
// ----------------------------------------------------------------------------
module stereo_biquad_tdf2_unit_test
    import sbq_pkg::*;
();

    localparam int SAMPLE_W = 24;
    localparam int FRAC_W = 28;
    localparam int GUARD_W = 8;
    localparam int Y_W = SAMPLE_W + GUARD_W;
    localparam int DELAY_W = Y_W + 2;
    localparam int DATA_W = ((2 * SAMPLE_W + 7) / 8) * 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 80;
    localparam int NUM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 172;
    localparam int PRESSURE_HOLD = 600;
    localparam logic [2:0] REG_SPARE = 3'(REG_A2) + 3'd1;
    localparam logic [31:0] COEF_ONE = 32'h1000_0000;
    localparam logic [31:0] COEF_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] COEF_MIN = 32'h8000_0000;
    localparam logic [31:0] COEF_NEG_ONE = 32'hF000_0000;
    localparam logic [23:0] S_MAX = 24'h7F_FFFF;
    localparam logic [23:0] S_MIN = 24'h80_0000;

    typedef enum logic {ROW_WRITE, ROW_PAIR} t_row_kind;

    typedef struct packed {
        logic [23:0] left;
        logic [23:0] right;
        logic        clip;
    } t_filtered;

    typedef struct packed {
        t_row_kind   kind;
        logic [2:0]  sel;
        logic [31:0] value;
        logic [23:0] left;
        logic [23:0] right;
        logic        check;
        t_filtered   want;
    } t_step_row;

    localparam t_filtered NO_WANT = '0;
    localparam int NUM_ROWS = 35;

    localparam t_step_row PLAN [NUM_ROWS] = '{
        // unity gain after reset
        '{ROW_PAIR, REG_B0, 32'h0, 24'h00_0000, 24'h00_0000, 1'b1, '{24'h0, 24'h0, 1'b0}},
        '{ROW_PAIR, REG_B0, 32'h0, S_MAX, S_MIN, 1'b1, '{S_MAX, S_MIN, 1'b0}},
        '{ROW_PAIR, REG_B0, 32'h0, S_MIN, S_MAX, 1'b1, '{S_MIN, S_MAX, 1'b0}},
        '{ROW_PAIR, REG_B0, 32'h0, 24'hFF_FFFF, 24'h00_0001, 1'b1,
          '{24'hFF_FFFF, 24'h00_0001, 1'b0}},
        '{ROW_PAIR, REG_B0, 32'h0, 24'hAA_AAAA, 24'h55_5555, 1'b1,
          '{24'hAA_AAAA, 24'h55_5555, 1'b0}},
        '{ROW_PAIR, REG_B0, 32'h0, 24'h55_5555, 24'hAA_AAAA, 1'b1,
          '{24'h55_5555, 24'hAA_AAAA, 1'b0}},
        // largest gain, output clamps
        '{ROW_WRITE, REG_B0, COEF_MAX, 24'h0, 24'h0, 1'b0, NO_WANT},
        '{ROW_PAIR, REG_B0, 32'h0, S_MAX, S_MIN, 1'b1, '{S_MAX, S_MIN, 1'b1}},
        '{ROW_PAIR, REG_B0, 32'h0, 24'h00_0000, 24'h00_0000, 1'b1, '{24'h0, 24'h0, 1'b0}},
        // most negative gain
        '{ROW_WRITE, REG_B0, COEF_MIN, 24'h0, 24'h0, 1'b0, NO_WANT},
        '{ROW_PAIR, REG_B0, 32'h0, S_MAX, S_MIN, 1'b1, '{S_MIN, S_MAX, 1'b1}},
        '{ROW_PAIR, REG_B0, 32'h0, 24'h00_0001, 24'hFF_FFFF, 1'b0, NO_WANT},
        // write beyond the last register is dropped
        '{ROW_WRITE, REG_SPARE, 32'h1234_5678, 24'h0, 24'h0, 1'b0, NO_WANT},
        '{ROW_PAIR, REG_B0, 32'h0, S_MAX, S_MAX, 1'b1, '{S_MIN, S_MIN, 1'b1}},
        // all coefficients at full scale, delays saturate
        '{ROW_WRITE, REG_B1, COEF_MAX, 24'h0, 24'h0, 1'b0, NO_WANT},
        '{ROW_WRITE, REG_B2, COEF_MAX, 24'h0, 24'h0, 1'b0, NO_WANT},
        '{ROW_WRITE, REG_A1, COEF_MIN, 24'h0, 24'h0, 1'b0, NO_WANT},
        '{ROW_WRITE, REG_A2, COEF_MIN, 24'h0, 24'h0, 1'b0, NO_WANT},
        '{ROW_WRITE, REG_B0, COEF_MAX, 24'h0, 24'h0, 1'b0, NO_WANT},
        '{ROW_PAIR, REG_B0, 32'h0, S_MAX, S_MIN, 1'b0, NO_WANT},
        '{ROW_PAIR, REG_B0, 32'h0, S_MAX, S_MIN, 1'b0, NO_WANT},
        '{ROW_PAIR, REG_B0, 32'h0, S_MIN, S_MAX, 1'b0, NO_WANT},
        '{ROW_PAIR, REG_B0, 32'h0, 24'h00_0000, 24'h00_0000, 1'b0, NO_WANT},
        // one-sample delay line
        '{ROW_WRITE, REG_B0, 32'h0, 24'h0, 24'h0, 1'b0, NO_WANT},
        '{ROW_WRITE, REG_B1, COEF_ONE, 24'h0, 24'h0, 1'b0, NO_WANT},
        '{ROW_WRITE, REG_B2, 32'h0, 24'h0, 24'h0, 1'b0, NO_WANT},
        '{ROW_WRITE, REG_A1, 32'h0, 24'h0, 24'h0, 1'b0, NO_WANT},
        '{ROW_WRITE, REG_A2, 32'h0, 24'h0, 24'h0, 1'b0, NO_WANT},
        '{ROW_PAIR, REG_B0, 32'h0, 24'h12_3456, 24'h65_4321, 1'b0, NO_WANT},
        '{ROW_PAIR, REG_B0, 32'h0, S_MAX, S_MIN, 1'b0, NO_WANT},
        '{ROW_PAIR, REG_B0, 32'h0, 24'h00_0000, 24'h00_0000, 1'b0, NO_WANT},
        // integrator, runs into the clamp
        '{ROW_WRITE, REG_A1, COEF_NEG_ONE, 24'h0, 24'h0, 1'b0, NO_WANT},
        '{ROW_PAIR, REG_B0, 32'h0, S_MAX, S_MIN, 1'b0, NO_WANT},
        '{ROW_PAIR, REG_B0, 32'h0, S_MAX, S_MIN, 1'b0, NO_WANT},
        '{ROW_PAIR, REG_B0, 32'h0, S_MAX, S_MIN, 1'b0, NO_WANT}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata;   // left_in, right_in
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [DATA_W-1:0] m_axis_tdata;   // left_out, right_out
    logic              m_axis_tuser;   // clipped
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [4:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    t_coefs                    coefs;
    logic signed [DELAY_W-1:0] dly1 [2];
    logic signed [DELAY_W-1:0] dly2 [2];
    t_filtered                 expected_pairs [$];

    int errors = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;

    stereo_biquad_tdf2_unit #(
        .SAMPLE_BITS   (SAMPLE_W),
        .COEF_FRAC_BITS(FRAC_W),
        .GUARD_BITS    (GUARD_W)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // floor(c * v / 2^frac), exact at these widths
    function automatic longint coef_mul(input logic signed [31:0] c, input longint v);
        return (longint'(c) * v) >>> FRAC_W;
    endfunction

    function automatic longint saturate(input longint v, input int w, inout bit hit);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo) begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic t_filtered filter_pair(input logic [23:0] l, input logic [23:0] r);
        t_filtered   res;
        logic [23:0] raw [2];
        logic [23:0] out [2];
        longint      x;
        longint      y;
        longint      n1;
        longint      n2;
        bit          hit;
        raw[0] = l;
        raw[1] = r;
        hit = 1'b0;
        for (int ch = 0; ch < 2; ch++) begin
            x = longint'($signed(raw[ch])) <<< GUARD_W;
            y = saturate(coef_mul(coefs.b0, x) + dly1[ch], Y_W, hit);
            n1 = coef_mul(coefs.b1, x) - coef_mul(coefs.a1, y) + dly2[ch];
            n2 = coef_mul(coefs.b2, x) - coef_mul(coefs.a2, y);
            dly1[ch] = DELAY_W'(saturate(n1, DELAY_W, hit));
            dly2[ch] = DELAY_W'(saturate(n2, DELAY_W, hit));
            out[ch] = SAMPLE_W'(y >>> GUARD_W);
        end
        res.left = out[0];
        res.right = out[1];
        res.clip = hit;
        return res;
    endfunction

    function automatic logic [23:0] random_sample();
        case ($urandom_range(0, 7))
            0: return S_MAX;
            1: return S_MIN;
            2: return 24'($urandom_range(0, 511)) - 24'd256;
            default: return 24'($urandom);
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_pair(input logic [23:0] l, input logic [23:0] r,
                             input logic use_typed, input t_filtered typed);
        t_filtered res;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do
                repeat ($urandom_range(1, 100)) @(negedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_axis_tdata <= DATA_W'({r, l});
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        res = filter_pair(l, r);
        expected_pairs.push_back(use_typed ? typed : res);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (expected_pairs.size() != 0);
        @(negedge i_clk);
    endtask

    task automatic program_coef(input logic [2:0] sel, input logic [31:0] val);
        wait_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (sel)
            REG_B0: coefs.b0 = val;
            REG_B1: coefs.b1 = val;
            REG_B2: coefs.b2 = val;
            REG_A1: coefs.a1 = val;
            REG_A2: coefs.a2 = val;
            default: ;
        endcase
        @(negedge i_clk);
        penable <= 1'b0;
        if (sel <= REG_A2) begin
            pwrite <= 1'b0;
            @(negedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            if (prdata !== val)
                report_mismatch("coefficient readback", prdata, val);
            @(negedge i_clk);
            penable <= 1'b0;
        end
        psel <= 1'b0;
    endtask

    task automatic configure_phase(input int mode);
        logic [31:0] val;
        logic [2:0]  sel;
        for (int k = 0; k <= int'(REG_A2); k++) begin
            sel = 3'(k);
            case (mode)
                0: begin
                    case (sel)
                        REG_A1: val = 32'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
                        REG_A2: val = 32'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000;
                        default: val = 32'($urandom_range(0, 32'h2000_0000)) - COEF_ONE;
                    endcase
                end
                1: val = $urandom;
                2: begin
                    case ($urandom_range(0, 4))
                        0: val = COEF_MAX;
                        1: val = COEF_MIN;
                        2: val = 32'h0;
                        3: val = COEF_ONE;
                        default: val = COEF_NEG_ONE;
                    endcase
                end
                default: val = (sel == REG_B0) ? COEF_ONE : 32'h0;
            endcase
            program_coef(sel, val);
        end
        if (mode == 3)
            program_coef(REG_SPARE, $urandom);
    endtask

    // receiver: random stalls plus one long hold-off
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if ($urandom_range(0, 99) < recv_stall_pct) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : output_check
        t_filtered want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_pairs.size() == 0) begin
                    report_mismatch("output beat with nothing pending",
                                    32'(m_axis_tdata[23:0]), 32'h0);
                end else begin
                    want = expected_pairs.pop_front();
                    if (m_axis_tdata[23:0] !== want.left)
                        report_mismatch("left_out", 32'(m_axis_tdata[23:0]), 32'(want.left));
                    if (m_axis_tdata[47:24] !== want.right)
                        report_mismatch("right_out", 32'(m_axis_tdata[47:24]),
                                        32'(want.right));
                    if (m_axis_tuser !== want.clip)
                        report_mismatch("clipped", 32'(m_axis_tuser), 32'(want.clip));
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("stereo_biquad_tdf2_unit test failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        coefs = '0;
        coefs.b0 = COEF_ONE;
        for (int ch = 0; ch < 2; ch++) begin
            dly1[ch] = '0;
            dly2[ch] = '0;
        end
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (PLAN[i]) begin
            if (PLAN[i].kind == ROW_WRITE)
                program_coef(PLAN[i].sel, PLAN[i].value);
            else
                send_pair(PLAN[i].left, PLAN[i].right, PLAN[i].check, PLAN[i].want);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            configure_phase((p + p / 4) % 4);
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 79;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 79;
                end
                default: begin
                    send_idle_pct = 24;
                    recv_stall_pct = 24;
                end
            endcase
            // fill the unit while the output is held off
            if (p == 0)
                hold_left = PRESSURE_HOLD;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_pair(random_sample(), random_sample(), 1'b0, NO_WANT);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0 && expected_pairs.size() == 0)
            $display("stereo_biquad_tdf2_unit test passed");
        else
            $display("stereo_biquad_tdf2_unit test failed");
        $finish;
    end

endmodule
